/* rtl/core/rpt_pkg.sv */
// types and constants shared by the regex pattern tokenizer
`timescale 1ns / 1ps

package rpt_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned KindW = 5;
    localparam int unsigned NibW  = 4;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESC    = 2'd1,
        MODE_HEX1   = 2'd2,
        MODE_HEX2   = 2'd3
    } scan_mode_t;

    typedef enum logic [KindW-1:0] {
        TK_EOF     = 5'd0,
        TK_QMARK   = 5'd1,
        TK_STAR    = 5'd2,
        TK_PLUS    = 5'd3,
        TK_ALT     = 5'd4,
        TK_DOT     = 5'd5,
        TK_CARET   = 5'd6,
        TK_LPAREN  = 5'd7,
        TK_RPAREN  = 5'd8,
        TK_LBRACK  = 5'd9,
        TK_RBRACK  = 5'd10,
        TK_LBRACE  = 5'd11,
        TK_RBRACE  = 5'd12,
        TK_COMMA   = 5'd13,
        TK_CHAR    = 5'd14,
        TK_CLASS   = 5'd15,
        TK_ESCAPED = 5'd16,
        TK_ERROR   = 5'd17
    } token_kind_t;

    typedef struct packed {
        scan_mode_t         mode;
        logic [NibW-1:0]    high_nibble;
        logic               halted;
        logic [ByteW-1:0]   last_byte;
    } scan_state_t;

    typedef struct packed {
        logic               emit;
        token_kind_t        kind;
        logic [ByteW-1:0]   value;
    } token_t;

endpackage

/* rtl/core/regex_pattern_tokenizer_top.sv */
// regex pattern tokenizer: byte stream in, token stream out
`timescale 1ns / 1ps

// channel   dir  tdata bits                              meaning
// s_        in   [7:0] pattern_byte                      one pattern byte per beat
// m_        out  [4:0] token_kind, [12:5] token_value    one token per beat
//
// a byte is taken into an input register, decoded combinationally from there and
// the token lands in the output register
// one byte per cycle unless m_ stalls, set by the single scan state update per byte
// aresetn (synchronous) clears the scan state, halt flag and both valid bits
// a stalled m_ side holds the token; the input register still drains bytes
// that make no token, and s_tready drops only when a token has no place to go

module regex_pattern_tokenizer_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pattern_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [4:0] token_kind, [12:5] token_value, [15:13] zero
);
    import rpt_pkg::*;

    logic              in_valid_reg;
    logic [ByteW-1:0]  in_byte_reg;
    scan_state_t       state_reg;
    scan_state_t       state_next;
    token_t            token;
    logic              out_valid_reg;
    token_kind_t       out_kind_reg;
    logic [ByteW-1:0]  out_value_reg;
    logic              out_free;
    logic              advance;

    rpt_decode u_decode (
        .byte_in    (in_byte_reg),
        .state_in   (state_reg),
        .state_next (state_next),
        .token      (token)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (out_free || !token.emit);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode        <= MODE_NORMAL;
            state_reg.high_nibble <= '0;
            state_reg.halted      <= 1'b0;
            state_reg.last_byte   <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= advance && token.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && advance && token.emit) begin
            out_kind_reg  <= token.kind;
            out_value_reg <= token.value;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_value_reg, out_kind_reg};

    // once halted, no new token is loaded
    a_halt_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.halted && !out_valid_reg) |=> !out_valid_reg)
        else $error("token produced while halted");

    // an error token always leaves the lexer halted
    a_error_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && token.emit && token.kind == TK_ERROR) |=> state_reg.halted)
        else $error("error token without halt");

    // end of pattern consumes nothing
    a_eof_keeps_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && token.emit && token.kind == TK_EOF) |=> $stable(state_reg))
        else $error("eof token changed scan state");

endmodule

/* rtl/core/rpt_decode.sv */
// per-byte lexer decode: token and next scan state from one pattern byte
`timescale 1ns / 1ps

module rpt_decode (
    input  logic [rpt_pkg::ByteW-1:0] byte_in,
    input  rpt_pkg::scan_state_t      state_in,
    output rpt_pkg::scan_state_t      state_next,
    output rpt_pkg::token_t           token
);
    import rpt_pkg::*;

    localparam logic [ByteW-1:0] ChNul   = 8'h00;
    localparam logic [ByteW-1:0] ChBslash = 8'h5C;
    localparam logic [ByteW-1:0] ChTab   = 8'h09;
    localparam logic [ByteW-1:0] ChLowT  = 8'h74;
    localparam logic [ByteW-1:0] ChLowX  = 8'h78;

    // metacharacter lookup, TK_EOF when the byte is not one
    function automatic token_kind_t meta_kind(input logic [ByteW-1:0] b);
        token_kind_t k;
        case (b)
            8'h3F:   k = TK_QMARK;   // ?
            8'h2A:   k = TK_STAR;    // *
            8'h2B:   k = TK_PLUS;    // +
            8'h7C:   k = TK_ALT;     // |
            8'h2E:   k = TK_DOT;     // .
            8'h5E:   k = TK_CARET;   // ^
            8'h28:   k = TK_LPAREN;
            8'h29:   k = TK_RPAREN;
            8'h5B:   k = TK_LBRACK;
            8'h5D:   k = TK_RBRACK;
            8'h7B:   k = TK_LBRACE;
            8'h7D:   k = TK_RBRACE;
            8'h2C:   k = TK_COMMA;
            default: k = TK_EOF;
        endcase
        return k;
    endfunction

    // {valid, digit value}
    function automatic logic [NibW:0] hex_digit(input logic [ByteW-1:0] b);
        logic [NibW:0] r;
        r = '0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

    logic              printable;
    logic              is_class;
    token_kind_t       mk;
    logic [NibW:0]     hx;

    assign printable = (byte_in >= 8'h20) && (byte_in <= 8'h7E);
    // d D w W s S
    assign is_class  = (byte_in == 8'h64) || (byte_in == 8'h44) || (byte_in == 8'h77)
                    || (byte_in == 8'h57) || (byte_in == 8'h73) || (byte_in == 8'h53);
    assign mk        = meta_kind(byte_in);
    assign hx        = hex_digit(byte_in);

    always_comb begin
        state_next  = state_in;
        token.emit  = 1'b0;
        token.kind  = TK_ERROR;
        token.value = byte_in;
        if (!state_in.halted) begin
            unique case (state_in.mode)
                MODE_NORMAL: begin
                    if (byte_in == ChNul) begin
                        token.emit  = 1'b1;
                        token.kind  = TK_EOF;
                        token.value = state_in.last_byte;
                    end else begin
                        state_next.last_byte = byte_in;
                        if (mk != TK_EOF) begin
                            token.emit = 1'b1;
                            token.kind = mk;
                        end else if (byte_in == ChBslash) begin
                            state_next.mode = MODE_ESC;
                        end else if (printable) begin
                            token.emit = 1'b1;
                            token.kind = TK_CHAR;
                        end else begin
                            token.emit        = 1'b1;
                            state_next.halted = 1'b1;
                        end
                    end
                end
                MODE_ESC: begin
                    if (byte_in == ChNul) begin
                        token.emit        = 1'b1;
                        state_next.halted = 1'b1;
                    end else begin
                        state_next.last_byte = byte_in;
                        state_next.mode      = MODE_NORMAL;
                        if (is_class) begin
                            token.emit = 1'b1;
                            token.kind = TK_CLASS;
                        end else if (byte_in == ChLowT) begin
                            token.emit  = 1'b1;
                            token.kind  = TK_CHAR;
                            token.value = ChTab;
                        end else if (byte_in == ChLowX) begin
                            state_next.mode = MODE_HEX1;
                        end else if (printable) begin
                            token.emit = 1'b1;
                            token.kind = TK_ESCAPED;
                        end else begin
                            token.emit        = 1'b1;
                            state_next.halted = 1'b1;
                        end
                    end
                end
                MODE_HEX1: begin
                    if (!hx[NibW]) begin
                        token.emit        = 1'b1;
                        state_next.halted = 1'b1;
                    end else begin
                        state_next.last_byte   = byte_in;
                        state_next.high_nibble = hx[NibW-1:0];
                        state_next.mode        = MODE_HEX2;
                    end
                end
                MODE_HEX2: begin
                    token.emit = 1'b1;
                    if (!hx[NibW]) begin
                        state_next.halted = 1'b1;
                    end else begin
                        state_next.last_byte = byte_in;
                        state_next.mode      = MODE_NORMAL;
                        token.kind           = TK_CHAR;
                        token.value          = {state_in.high_nibble, hx[NibW-1:0]};
                    end
                end
                default: begin
                    state_next = state_in;
                end
            endcase
        end
    end

endmodule
